>>> hdl/slae_pkg.sv
// types, opcodes and condition codes shared by the lane execute stage
// no dependencies; used by slae_cond, slae_alu and simd_lane_alu_execute
package slae_pkg;

    localparam int DATA_W = 16;
    localparam int INSTR_W = 32;
    localparam int FLAGS_W = 4;
    localparam int IDX_W = 4;

    // flag bit positions in the kept flags
    localparam int FLAG_N = 0;
    localparam int FLAG_Z = 1;
    localparam int FLAG_V = 2;
    localparam int FLAG_C = 3;

    // opcodes of the alu class (opcode bit 4 set)
    localparam logic [4:0] OPC_OR     = 5'h10;
    localparam logic [4:0] OPC_XOR    = 5'h11;
    localparam logic [4:0] OPC_AND    = 5'h12;
    localparam logic [4:0] OPC_TST    = 5'h13;
    localparam logic [4:0] OPC_MOV    = 5'h14;
    localparam logic [4:0] OPC_RGBADD = 5'h16;
    localparam logic [4:0] OPC_RGBSHR = 5'h17;
    localparam logic [4:0] OPC_ADD    = 5'h18;

    // first operand inversion decode for the subtract forms
    localparam logic [4:0] OPC_INV1_MASK = 5'h1b;
    localparam logic [4:0] OPC_INV1_VAL  = 5'h19;
    // destination kind and bit 7 that flip the second operand inversion
    localparam logic [31:0] INV2_FLIP_MASK = 32'h0030_0080;

    // destination kinds
    localparam logic [1:0] KIND_CACHE = 2'd0;
    localparam logic [1:0] KIND_SPEC  = 2'd3;

    // move modes
    localparam logic [1:0] MMODE_SREG  = 2'd1;
    localparam logic [1:0] MMODE_PERIPH = 2'd3;

    typedef enum logic [3:0] {
        COND_AL, COND_EQ, COND_NE, COND_CS, COND_CC, COND_MI, COND_PL, COND_VS,
        COND_VC, COND_HI, COND_LS, COND_GE, COND_LT, COND_GT, COND_LE, COND_NV
    } cond_t;

    typedef struct packed {
        logic [INSTR_W-1:0] instr;
        logic [DATA_W-1:0]  operand_a;
        logic [DATA_W-1:0]  operand_b;
        logic               use_first;
        logic               source_is_periph;
        logic               periph_ok;
    } lane_in_t;

    typedef struct packed {
        logic [DATA_W-1:0]  result;
        logic [FLAGS_W-1:0] flags;
        logic               carry;
        logic               write_reg;
        logic               write_sreg;
        logic               write_cache;
        logic               write_periph;
    } alu_out_t;

endpackage

>>> hdl/simd_lane_alu_execute.sv
// an input transaction passes through the input register and then the result register
// throughput: one transaction per cycle unless m_tready stalls the output; the kept flags
// and carry update as an item moves from the input register to the result register, so
// the next item sees them
// reset: synchronous active-low aresetn clears both valid bits, flags and carry
// top level of the lane execute stage; depends on slae_pkg, slae_cond, slae_alu
module simd_lane_alu_execute (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [31:0] instr, [47:32] operand_a, [63:48] operand_b, [64] use_first,
    // [65] source_is_periph, [66] periph_ok, [71:67] zero
    input  logic [71:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] cond_pass, [16:1] result, [20:17] flags_out, [21] carry_out, [22] write_reg,
    // [23] write_sreg, [24] write_cache, [25] write_periph, [29:26] dest_index, [31:30] zero
    output logic [31:0] m_tdata
);

    slae_pkg::lane_in_t in_reg;
    logic               in_valid_reg;
    slae_pkg::alu_out_t out_reg;
    logic               out_cond_reg;
    logic [3:0]         out_dest_reg;
    logic               out_valid_reg;
    logic [3:0]         flags_reg;
    logic               carry_reg;

    logic               advance;
    logic               cond_pass;
    slae_pkg::alu_out_t alu_out;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    slae_cond u_cond (
        .cond      (in_reg.instr[31:28]),
        .flags     (flags_reg),
        .cond_pass (cond_pass)
    );

    slae_alu u_alu (
        .item      (in_reg),
        .cond_pass (cond_pass),
        .flags     (flags_reg),
        .carry     (carry_reg),
        .alu_out   (alu_out)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg <= '0;
            carry_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                flags_reg <= alu_out.flags;
                carry_reg <= alu_out.carry;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_reg.instr <= s_tdata[31:0];
            in_reg.operand_a <= s_tdata[47:32];
            in_reg.operand_b <= s_tdata[63:48];
            in_reg.use_first <= s_tdata[64];
            in_reg.source_is_periph <= s_tdata[65];
            in_reg.periph_ok <= s_tdata[66];
        end
        if (advance) begin
            out_reg <= alu_out;
            out_cond_reg <= cond_pass;
            out_dest_reg <= in_reg.instr[19:16];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = {2'b00, out_dest_reg, out_reg.write_periph, out_reg.write_cache,
                      out_reg.write_sreg, out_reg.write_reg, out_reg.carry, out_reg.flags,
                      out_reg.result, out_cond_reg};

`ifndef SYNTHESIS
    // a failed condition leaves no result and no write
    a_fail_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_cond_reg) |-> (out_reg.result == '0 &&
        !out_reg.write_reg && !out_reg.write_sreg && !out_reg.write_cache &&
        !out_reg.write_periph))
        else $error("result or write enable set with failed condition");

    // kept flags and carry only move when an item advances
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> ($stable(flags_reg) && $stable(carry_reg)))
        else $error("flags or carry changed without an advancing item");

    // at most one destination is written
    a_one_dest: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> $onehot0({out_reg.write_reg, out_reg.write_sreg,
        out_reg.write_cache, out_reg.write_periph}))
        else $error("more than one write enable set");

    // input side only stalls while an item is held
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && out_valid_reg))
        else $error("input stalled with room in the pipeline");
`endif

endmodule

>>> hdl/slae_cond.sv
// condition code test against the kept nzvc flags
// depends on slae_pkg
module slae_cond (
    input  logic [3:0]                  cond,
    input  logic [slae_pkg::FLAGS_W-1:0] flags,
    output logic                        cond_pass
);

    logic n, z, v, c;

    assign n = flags[slae_pkg::FLAG_N];
    assign z = flags[slae_pkg::FLAG_Z];
    assign v = flags[slae_pkg::FLAG_V];
    assign c = flags[slae_pkg::FLAG_C];

    always_comb begin
        case (slae_pkg::cond_t'(cond))
            slae_pkg::COND_AL: cond_pass = 1'b1;
            slae_pkg::COND_EQ: cond_pass = z;
            slae_pkg::COND_NE: cond_pass = !z;
            slae_pkg::COND_CS: cond_pass = c;
            slae_pkg::COND_CC: cond_pass = !c;
            slae_pkg::COND_MI: cond_pass = n;
            slae_pkg::COND_PL: cond_pass = !n;
            slae_pkg::COND_VS: cond_pass = v;
            slae_pkg::COND_VC: cond_pass = !v;
            slae_pkg::COND_HI: cond_pass = c && !z;
            slae_pkg::COND_LS: cond_pass = !c || z;
            slae_pkg::COND_GE: cond_pass = (n == v);
            slae_pkg::COND_LT: cond_pass = (n != v);
            slae_pkg::COND_GT: cond_pass = !z && (n == v);
            slae_pkg::COND_LE: cond_pass = z || (n != v);
            default:           cond_pass = 1'b0;
        endcase
    end

endmodule

>>> hdl/slae_alu.sv
// alu datapath: operand inversion, logic/rgb565/add ops, flags and write enables
// depends on slae_pkg
module slae_alu (
    input  slae_pkg::lane_in_t          item,
    input  logic                        cond_pass,
    input  logic [slae_pkg::FLAGS_W-1:0] flags,
    input  logic                        carry,
    output slae_pkg::alu_out_t          alu_out
);

    logic [4:0]                  opc;
    logic [1:0]                  kind;
    logic [1:0]                  mmode;
    logic                        go;
    logic                        inv1, inv2;
    logic [slae_pkg::DATA_W-1:0] p1, p2, shr_src;
    logic [slae_pkg::DATA_W:0]   sum;
    logic                        cin;
    logic [4:0]                  rgb_r, rgb_b;
    logic [5:0]                  rgb_g;
    logic [slae_pkg::DATA_W-1:0] res;
    logic                        carry_new;
    logic                        w_reg, w_sreg, w_cache, w_per;
    logic                        fn, fz, fv, fc;

    assign opc   = item.instr[27:23];
    assign kind  = item.instr[21:20];
    assign mmode = item.instr[13:12];
    assign go    = opc[4] && cond_pass;

    assign inv2 = ((opc[3] && opc[1]) !=
                   ((item.instr & slae_pkg::INV2_FLIP_MASK) == slae_pkg::INV2_FLIP_MASK));
    assign inv1 = item.use_first ? inv2
                : ((opc & slae_pkg::OPC_INV1_MASK) == slae_pkg::OPC_INV1_VAL);
    assign p1 = inv1 ? ~item.operand_a : item.operand_a;
    assign p2 = inv2 ? ~item.operand_b : item.operand_b;

    // plain add takes no carry in, the others take one or the kept carry
    assign cin = opc[2] ? carry : (opc != slae_pkg::OPC_ADD);
    assign sum = {1'b0, p1} + {1'b0, p2} + {{slae_pkg::DATA_W{1'b0}}, cin};

    assign shr_src = item.use_first ? p1 : p2;
    // per-channel add wraps inside each channel
    assign rgb_r = p1[15:11] + p2[15:11];
    assign rgb_g = p1[10:5] + p2[10:5];
    assign rgb_b = p1[4:0] + p2[4:0];

    always_comb begin
        res = '0;
        carry_new = carry;
        if (go) begin
            if (opc[3]) begin
                res = sum[slae_pkg::DATA_W-1:0];
                carry_new = sum[slae_pkg::DATA_W];
            end else begin
                carry_new = 1'b0;
                case (opc)
                    slae_pkg::OPC_AND,
                    slae_pkg::OPC_TST:    res = p1 & p2;
                    slae_pkg::OPC_OR:     res = p1 | p2;
                    slae_pkg::OPC_XOR:    res = p1 ^ p2;
                    slae_pkg::OPC_RGBSHR: res = {1'b0, shr_src[15:12], 1'b0, shr_src[10:6],
                                                 1'b0, shr_src[4:1]};
                    slae_pkg::OPC_RGBADD: res = {rgb_r, rgb_g, rgb_b};
                    default:              res = item.use_first ? p1 : p2;
                endcase
            end
        end
    end

    always_comb begin
        w_reg = 1'b0;
        w_sreg = 1'b0;
        w_per = 1'b0;
        w_cache = go && (kind == slae_pkg::KIND_CACHE);
        if (go && !w_cache && (opc[2:0] != 3'd3)) begin
            if (opc == slae_pkg::OPC_MOV) begin
                w_reg = !item.instr[12];
                w_sreg = (mmode == slae_pkg::MMODE_SREG);
                w_per = (mmode == slae_pkg::MMODE_PERIPH);
            end else begin
                w_reg = (kind != slae_pkg::KIND_SPEC) || !item.instr[5];
                w_sreg = !w_reg;
            end
        end
    end

    always_comb begin
        fz = (res == '0);
        fc = carry_new;
        fv = res[15] ^ p1[15] ^ p2[15] ^ carry_new;
        fn = res[15];
        if (item.source_is_periph || w_per) begin
            fn = !item.periph_ok;
            fz = 1'b0;
            fc = 1'b0;
            fv = 1'b0;
        end
    end

    always_comb begin
        alu_out.result = res;
        alu_out.carry = carry_new;
        alu_out.flags = flags;
        if (go && item.instr[22]) begin
            alu_out.flags[slae_pkg::FLAG_N] = fn;
            alu_out.flags[slae_pkg::FLAG_Z] = fz;
            alu_out.flags[slae_pkg::FLAG_V] = fv;
            alu_out.flags[slae_pkg::FLAG_C] = fc;
        end
        alu_out.write_reg = w_reg;
        alu_out.write_sreg = w_sreg;
        alu_out.write_cache = w_cache;
        alu_out.write_periph = w_per;
    end

endmodule
